@@ hw/rtl/bed_pkg.sv @@
// Package for the bin edge digitizer.
// Holds the command and register codes, the sequencer states and the result struct.
// No dependencies.
package bed_pkg;

  // Width of the bin_index result field.
  localparam int BIN_W = 9;

  // Command codes carried in the input tuser.
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_CLOSED = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_EDGE_COUNT   = 1'b1;

  // Search sequencer states.
  typedef enum logic [1:0] {
    SR_IDLE,
    SR_PROBE,
    SR_FINISH
  } search_state_t;

  // Result handed from the search unit to the output register.
  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] bin;
  } result_t;

endpackage

@@ hw/rtl/bed_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the bin edge table. No dependencies.
module bed_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bed_search.sv @@
// Binary search sequencer for the bin edge digitizer.
// One comparator probes one table entry per cycle; depends on bed_pkg.
module bed_search #(
  parameter int MAX_EDGES = 256,
  parameter int VALUE_BITS = 32,
  parameter int CW = $clog2(MAX_EDGES + 1),
  parameter int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CW-1:0]         count,
  input  logic [VALUE_BITS-1:0] sample,
  input  logic                  right_closed,
  input  logic                  out_free,
  input  logic [VALUE_BITS-1:0] rd_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  output logic                  busy,
  output bed_pkg::result_t      result
);

  import bed_pkg::*;

  search_state_t         state, state_next;
  logic [CW-1:0]         lo, lo_next;
  logic [CW-1:0]         hi, hi_next;
  logic [CW-1:0]         mid, mid_next;
  logic [VALUE_BITS-1:0] sample_q;

  logic                  go_up;
  logic [CW-1:0]         lo_probe;
  logic [CW-1:0]         hi_probe;
  logic [CW:0]           mid_sum;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search bounds and the sample under test.
  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (start) begin
      sample_q <= sample;
    end
  end

  // The shared comparator: the edge read for mid against the sample.
  always_comb begin
    if (right_closed) begin
      go_up = $signed(rd_data) < $signed(sample_q);
    end else begin
      go_up = $signed(rd_data) <= $signed(sample_q);
    end
    lo_probe = go_up ? (mid + CW'(1)) : lo;
    hi_probe = go_up ? hi : mid;
    mid_sum  = {1'b0, lo_probe} + {1'b0, hi_probe};
  end

  // Next state, table reads and result hand-off.
  always_comb begin
    state_next    = state;
    lo_next       = lo;
    hi_next       = hi;
    mid_next      = mid;
    rd_en         = 1'b0;
    rd_addr       = mid[AW-1:0];
    result.valid  = 1'b0;
    result.bin    = BIN_W'(lo);
    case (state)
      SR_IDLE: begin
        if (start) begin
          lo_next = '0;
          hi_next = count;
          if (count == '0) begin
            state_next = SR_FINISH;
          end else begin
            mid_next   = count >> 1;
            rd_en      = 1'b1;
            rd_addr    = mid_next[AW-1:0];
            state_next = SR_PROBE;
          end
        end
      end
      SR_PROBE: begin
        lo_next = lo_probe;
        hi_next = hi_probe;
        if (lo_probe < hi_probe) begin
          mid_next = mid_sum[CW:1];
          rd_en    = 1'b1;
          rd_addr  = mid_next[AW-1:0];
        end else if (out_free) begin
          result.valid = 1'b1;
          result.bin   = BIN_W'(lo_probe);
          state_next   = SR_IDLE;
        end else begin
          state_next = SR_FINISH;
        end
      end
      SR_FINISH: begin
        if (out_free) begin
          result.valid = 1'b1;
          state_next   = SR_IDLE;
        end
      end
      default: begin
        state_next = SR_IDLE;
      end
    endcase
  end

  assign busy = (state != SR_IDLE);

endmodule

@@ hw/rtl/bin_edge_digitizer.sv @@
// Bin edge digitizer: top level with the stream ports, configuration registers,
// edge table and output register. Depends on bed_pkg, bed_ram and bed_search.
//
// Usage: the input stream carries requests. tuser selects the command: a load
// request writes edge_value into the table at edge_index (ignored when the
// index is beyond the table) and gives no result; a classify request gives one
// result on the output stream, the bin index of sample_value.
// The configuration port sets right_closed and edge_count; write it only while
// the block is idle.
// Search: a classify runs the binary search, one table read per probe, over
// the first edge_count entries of the table (at most MAX_EDGES); then the
// result goes to the output register. The single read port of the edge table
// and the one comparator mean that each cycle reads one edge and compares it.
// The input is not ready while a classify is in progress. The finished result
// sits in the output register; a stalled receiver holds it there, and the
// block still takes new requests. A later classify waits at its end until the
// output register is free.
// Reset clears the registers to right_closed = 0 and edge_count = 1 and empties
// the output register; the edge table holds nothing until loaded.
module bin_edge_digitizer #(
  parameter int MAX_EDGES = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tdata: edge_index [7:0], edge_value [39:8], sample_value [71:40].
  input  logic [71:0]                      s_tdata,
  // tuser: command [0].
  input  logic                             s_tuser,
  // Output stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tdata: bin_index [8:0], zero fill [15:9].
  output logic [15:0]                      m_tdata,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [bed_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bed_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import bed_pkg::*;

  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CMPW = (CW > 9) ? CW : 9;
  localparam int IW   = (AW > 8) ? AW + 1 : 9;

  logic                  right_closed;
  logic [8:0]            edge_count;
  logic [CMPW-1:0]       count_ext;
  logic [CW-1:0]         count_sat;

  logic [7:0]            edge_index;
  logic [31:0]           edge_value;
  logic [31:0]           sample_value;

  logic                  in_fire;
  logic                  load_we;
  logic                  start;
  logic                  out_free;
  logic                  busy;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  result_t               result;
  logic [BIN_W-1:0]      bin_index;

  // Unpack the request.
  assign edge_index   = s_tdata[7:0];
  assign edge_value   = s_tdata[39:8];
  assign sample_value = s_tdata[71:40];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      right_closed <= 1'b0;
      edge_count   <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RIGHT_CLOSED: right_closed <= cfg_data[0];
        REG_EDGE_COUNT:   edge_count   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Edge count saturated to the table depth.
  always_comb begin
    count_ext = CMPW'(edge_count);
    if (count_ext > CMPW'(MAX_EDGES)) begin
      count_sat = CW'(MAX_EDGES);
    end else begin
      count_sat = CW'(count_ext);
    end
  end

  // Request handshake and command decode.
  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign load_we  = in_fire && (s_tuser == CMD_LOAD) &&
                    (IW'(edge_index) < IW'(MAX_EDGES));
  assign start    = in_fire && (s_tuser == CMD_CLASSIFY);
  assign out_free = !m_tvalid || m_tready;

  // Edge table.
  bed_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_EDGES)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(edge_index)),
    .wdata (VALUE_BITS'(edge_value)),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Binary search sequencer.
  bed_search #(
    .MAX_EDGES  (MAX_EDGES),
    .VALUE_BITS (VALUE_BITS)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .count        (count_sat),
    .sample       (VALUE_BITS'(sample_value)),
    .right_closed (right_closed),
    .out_free     (out_free),
    .rd_data      (rd_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .busy         (busy),
    .result       (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      bin_index <= result.bin;
    end
  end

  assign m_tdata = {7'd0, bin_index};

  // A result is handed over only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!m_tvalid || m_tready))
    else $error("search result overwrote a pending output");

  // A load request never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && (s_tuser == CMD_LOAD)) |=> !result.valid)
    else $error("load request produced a result");

  // A classify request holds off the input until its search ends.
  assert property (@(posedge clk) disable iff (rst)
    start |=> !s_tready)
    else $error("input ready during a classify");

  // A bin index never exceeds the number of edges in use.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CMPW'(bin_index) <= CMPW'(count_sat)))
    else $error("bin index beyond edge count");

endmodule

@@ test/bin_edge_digitizer_tb.sv @@
// Self-checking testbench for bin_edge_digitizer: random stream traffic with
// a built-in bin search predictor. Depends on bed_pkg and the digitizer RTL.
`timescale 1ns / 1ps

module bin_edge_digitizer_tb;
  import bed_pkg::*;

  localparam int TARGET_ITEMS = 700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] V_MAX = 32'sh7fff_ffff;

  // One request on the input stream.
  typedef struct packed {
    logic              cmd;
    logic [7:0]        idx;
    logic signed [31:0] edge_v;
    logic signed [31:0] smp;
  } bin_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bin_edge_digitizer DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: the edge table and registers as the block should hold them.
  logic signed [31:0] edge_tbl [256];
  logic               pred_rc = 1'b0;
  logic [8:0]         pred_cnt = 9'd1;
  logic [8:0]         bins_due [$];

  // Stimulus-side mirror, used only to keep classify requests on loaded entries.
  logic signed [31:0] gen_tbl [256];
  bit                 gen_written [256];
  bin_req_t           pend_q [$];

  int errors = 0;
  int n_queued = 0;
  int n_loads = 0;
  int n_classifies = 0;
  int n_results = 0;
  int n_writes = 0;
  int cycles = 0;

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Binary search as the block does it: count edges at or below (or strictly
  // below, in right-closed mode) the sample, probing at (lo+hi)/2.
  function automatic logic [8:0] bin_of(logic signed [31:0] smp);
    int lo, hi, mid, n;
    bit up;
    n = (pred_cnt > 9'd256) ? 256 : int'(pred_cnt);
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      up = pred_rc ? (edge_tbl[mid] < smp) : (edge_tbl[mid] <= smp);
      if (up) lo = mid + 1;
      else hi = mid;
    end
    return lo[8:0];
  endfunction

  task automatic accept_request(bin_req_t r);
    if (r.cmd == CMD_LOAD) begin
      edge_tbl[r.idx] = r.edge_v;
      n_loads++;
    end else begin
      bins_due.push_back(bin_of(r.smp));
      n_classifies++;
    end
  endtask

  task automatic check_result(logic [15:0] data);
    logic [8:0] want;
    n_results++;
    if (bins_due.size() == 0) begin
      flag_error($sformatf("result bin %0d arrived with nothing expected", data[8:0]));
    end else begin
      want = bins_due.pop_front();
      if (data[8:0] != want)
        flag_error($sformatf("bin_index %0d, expected %0d", data[8:0], want));
      if (data[15:9] != '0)
        flag_error($sformatf("zero fill of result is %0h", data[15:9]));
    end
  endtask

  // Sender pacing: mostly back to back, some short gaps, a few long ones,
  // and stretches with no gaps at all.
  int send_calm = 0;
  function automatic int pick_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) send_calm = $urandom_range(20, 60);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  int recv_calm = 0;
  function automatic int pick_stall();
    int r;
    if (recv_calm > 0) begin
      recv_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) recv_calm = $urandom_range(30, 100);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers the queued requests and predicts each one as it is taken.
  bin_req_t cur_req;
  int       gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) accept_request(cur_req);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          cur_req = pend_q.pop_front();
          s_tuser <= cur_req.cmd;
          s_tdata <= {cur_req.smp, cur_req.edge_v, cur_req.idx};
          s_tvalid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and throttles the output, with one long hold-off
  // once traffic is flowing and requests are still queued, so that the block
  // backs up into its input.
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && n_results >= 60 && pend_q.size() >= 4) begin
        hold_done = 1'b1;
        hold_left = 400;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_stall();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               bins_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return V_MIN;
    if (r < 16) return V_MAX;
    if (r < 36) return 32'(int'($urandom_range(0, 400)) - 200);
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_sample(int n);
    logic signed [31:0] e;
    if (n > 0 && $urandom_range(0, 99) < 60) begin
      e = gen_tbl[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 2))
        0: e = e - 1;
        2: e = e + 1;
        default: ;
      endcase
      return e;
    end
    return rand_val();
  endfunction

  task automatic push_load(int idx, logic signed [31:0] val);
    bin_req_t r;
    r.cmd = CMD_LOAD;
    r.idx = idx[7:0];
    r.edge_v = val;
    r.smp = $urandom;
    pend_q.push_back(r);
    gen_tbl[idx] = val;
    gen_written[idx] = 1'b1;
    n_queued++;
  endtask

  task automatic push_classify(logic signed [31:0] smp);
    bin_req_t r;
    r.cmd = CMD_CLASSIFY;
    r.idx = 8'($urandom);
    r.edge_v = $urandom;
    r.smp = smp;
    pend_q.push_back(r);
    n_queued++;
  endtask

  // Load a non-decreasing set of edges, with repeats, in rising or falling
  // index order.
  task automatic load_sorted(int n);
    logic signed [31:0] vals [256];
    longint v, span, step;
    int i, r;
    bit down;
    span = 64'sh1_0000_0000 / (n + 1);
    if ($urandom_range(0, 6) == 0) v = -64'sh8000_0000;
    else v = -64'sh8000_0000 + (longint'($urandom) % (2 * span));
    for (i = 0; i < n; i++) begin
      if (v > 64'sh7fff_ffff) v = 64'sh7fff_ffff;
      vals[i] = v[31:0];
      r = $urandom_range(0, 99);
      if (r < 20) step = 0;
      else if (r < 50) step = longint'($urandom_range(1, 50));
      else step = longint'($urandom) % (2 * span);
      v = v + step;
    end
    down = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n; i++) begin
      r = down ? n - 1 - i : i;
      push_load(r, vals[r]);
    end
  endtask

  // Wait until every request is taken and every result has come back, then
  // let the block settle after any trailing load.
  task automatic wait_idle();
    do @(negedge clk);
    while (pend_q.size() != 0 || s_tvalid || bins_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_RIGHT_CLOSED) pred_rc = data[0];
    else pred_cnt = data;
    n_writes++;
  endtask

  // Right-closed register written with junk in the unused upper bits.
  task automatic set_mode(logic rc);
    logic [7:0] junk;
    junk = 8'($urandom);
    write_reg(REG_RIGHT_CLOSED, {junk, rc});
  endtask

  initial begin
    int phase, r, cnt, n_eff, k, i;
    bit need;
    for (i = 0; i < 256; i++) begin
      gen_written[i] = 1'b0;
      gen_tbl[i] = '0;
      edge_tbl[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: left-closed, one edge. Zero, both extremes, both ends
    // of the table index.
    push_load(0, 0);
    push_classify(0);
    push_classify(-1);
    push_classify(1);
    push_classify(V_MIN);
    push_classify(V_MAX);
    push_load(255, V_MAX);
    push_load(0, V_MIN);
    push_classify(V_MIN);
    push_load(0, V_MAX);
    push_classify(V_MAX);
    push_classify(V_MIN);
    wait_idle();

    // Right-closed: a sample equal to the edge no longer counts it.
    set_mode(1'b1);
    push_classify(V_MAX);
    push_classify(V_MIN);
    wait_idle();

    // Edge count zero searches nothing.
    write_reg(REG_EDGE_COUNT, 9'd0);
    push_classify(0);
    push_classify(V_MAX);
    wait_idle();

    // A table that is not monotonic, in both modes.
    set_mode(1'b0);
    write_reg(REG_EDGE_COUNT, 9'd3);
    push_load(0, 5);
    push_load(1, -5);
    push_load(2, 5);
    push_classify(0);
    push_classify(5);
    wait_idle();
    set_mode(1'b1);
    push_classify(5);

    // Random phases: mostly sorted tables searched near their edges, with
    // stray loads mixed in. One full table and one oversized count.
    phase = 0;
    while (n_queued < TARGET_ITEMS) begin
      wait_idle();
      if (phase == 2) begin
        cnt = 256;
      end else if (phase == 5) begin
        cnt = $urandom_range(257, 511);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) cnt = 0;
        else if (r < 80) cnt = $urandom_range(1, 16);
        else cnt = $urandom_range(17, 64);
      end
      set_mode(1'($urandom_range(0, 1)));
      write_reg(REG_EDGE_COUNT, cnt[8:0]);
      n_eff = (cnt > 256) ? 256 : cnt;
      need = 1'b0;
      for (i = 0; i < n_eff; i++)
        if (!gen_written[i]) need = 1'b1;
      if (n_eff > 0 && (need || (n_eff <= 64 && $urandom_range(0, 1) == 1)))
        load_sorted(n_eff);
      k = $urandom_range(8, 30);
      repeat (k) begin
        if ($urandom_range(0, 99) < 12) push_load($urandom_range(0, 255), rand_val());
        else push_classify(pick_sample(n_eff));
      end
      phase++;
    end
    wait_idle();

    $display("Covered %0d requests: %0d edge loads and %0d classifies, %0d results checked,",
             n_queued, n_loads, n_classifies, n_results);
    $display("across %0d register writes in %0d random phases plus the directed cases.",
             n_writes, phase);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bed_pkg.sv
hw/rtl/bed_ram.sv
hw/rtl/bed_search.sv
hw/rtl/bin_edge_digitizer.sv
test/bin_edge_digitizer_tb.sv
